// ----- hw/rtl/sqtm_pkg.sv -----
// Package for the single-server queue tick model: sizing constants,
// the queue entry and result types shared by the top level and its parts.
// Depends on nothing.
`default_nettype none

package sqtm_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int SERVICE_BITS = 4;

  localparam int IN_SVC_W  = 4;
  localparam int SVC_EXT_W = (SERVICE_BITS > IN_SVC_W) ? SERVICE_BITS : IN_SVC_W;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int TICK_W    = 32;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 48;
  localparam int QLEN_W    = 5;
  localparam int OCC_EXT_W = (OCC_W > QLEN_W) ? OCC_W : QLEN_W;

  typedef struct packed {
    logic [TICK_W-1:0]       arrive_tick;
    logic [SERVICE_BITS-1:0] service;
  } sqtm_entry_t;

  typedef struct packed {
    logic [QLEN_W-1:0] queue_length;
    logic [CNT_W-1:0]  arrived_total;
    logic [CNT_W-1:0]  served_total;
    logic [CNT_W-1:0]  turned_away_total;
    logic [SUM_W-1:0]  length_sum;
    logic [SUM_W-1:0]  wait_sum;
    logic              started_service;
  } sqtm_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sqtm_queue_mem.sv -----
// Queue storage for the tick model: synchronous RAM with a registered read
// and a bypass for a write that lands on the address read in the same cycle.
// Depends on sqtm_pkg.
`default_nettype none

module sqtm_queue_mem (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [sqtm_pkg::PTR_W-1:0] wr_addr,
  input  sqtm_pkg::sqtm_entry_t    wr_data,
  input  logic [sqtm_pkg::PTR_W-1:0] rd_addr,
  output sqtm_pkg::sqtm_entry_t    rd_data
);
  import sqtm_pkg::*;

  sqtm_entry_t mem [QUEUE_DEPTH];
  sqtm_entry_t rd_q_r;
  sqtm_entry_t fwd_data_r;
  logic        fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r     <= mem[rd_addr];
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  // A write to the address being read returns the new data.
  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sqtm_out_skid.sv -----
// Two-entry output buffer for the tick model's results, so that a new
// transaction can be taken while a finished result waits. Depends on sqtm_pkg.
`default_nettype none

module sqtm_out_skid (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sqtm_pkg::sqtm_result_t in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sqtm_pkg::sqtm_result_t out_data
);
  import sqtm_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  sqtm_result_t out_data_r, out_data_nxt;
  sqtm_result_t skid_data_r, skid_data_nxt;
  logic         take;
  logic         push;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    take = out_valid_r && out_ready;
    push = in_valid && !skid_valid_r;
    if (push) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = in_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = in_data;
      end
    end else if (take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/single_server_queue_tick_model.sv -----
// Top level of the single-server queue tick model: tick update logic,
// queue RAM and output buffer. Depends on sqtm_pkg, sqtm_queue_mem and
// sqtm_out_skid.
`default_nettype none

// Each input transaction is one simulated tick and yields exactly one result
// transaction. The block takes one tick per clock cycle while in_ready is high:
// the whole update (enqueue, dequeue, service countdown and the saturating
// counter adds) is done in the cycle of acceptance, and the result is
// registered in a two-entry output buffer, which lets input keep flowing
// while one result waits. Waiting clients are held in a synchronous RAM of
// QUEUE_DEPTH entries; its address is issued ahead from the next head of the
// queue, so the rate is set by the registered RAM read together with its
// write bypass and by the combinational counter logic. There is no clearing
// pass after reset: only entries that hold clients are ever used.

module single_server_queue_tick_model (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_client_arrives,
  input  logic [3:0]  in_service_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_queue_length,
  output logic [31:0] out_arrived_total,
  output logic [31:0] out_served_total,
  output logic [31:0] out_turned_away_total,
  output logic [47:0] out_length_sum,
  output logic [47:0] out_wait_sum,
  output logic        out_started_service
);
  import sqtm_pkg::*;

  // Architectural state of the simulation.
  logic [PTR_W-1:0]        head_r, head_nxt;
  logic [OCC_W-1:0]        occ_r, occ_nxt;
  logic [SERVICE_BITS-1:0] svc_rem_r, svc_rem_nxt;
  logic [TICK_W-1:0]       tick_r, tick_nxt;
  logic [CNT_W-1:0]        arrived_r, arrived_nxt;
  logic [CNT_W-1:0]        served_r, served_nxt;
  logic [CNT_W-1:0]        turned_r, turned_nxt;
  logic [SUM_W-1:0]        len_sum_r, len_sum_nxt;
  logic [SUM_W-1:0]        wait_sum_r, wait_sum_nxt;

  logic                    accept;
  logic                    skid_ready;
  logic [SVC_EXT_W-1:0]    svc_ext;
  sqtm_entry_t             new_entry;
  sqtm_entry_t             mem_head;
  sqtm_entry_t             head_entry;
  logic                    full;
  logic                    enq;
  logic                    start;
  logic [OCC_W-1:0]        occ_enq;
  logic [OCC_W:0]          tail_sum;
  logic [OCC_W:0]          tail_wrap;
  logic [PTR_W-1:0]        tail;
  logic [PTR_W:0]          head_inc;
  logic [TICK_W-1:0]       wait_ticks;
  logic [SUM_W:0]          len_add;
  logic [SUM_W:0]          wait_add;
  logic [OCC_EXT_W-1:0]    occ_ext;
  sqtm_result_t            result;

  assign accept   = in_valid && skid_ready;
  assign in_ready = skid_ready;

  // Only the low SERVICE_BITS bits of the service time are kept.
  assign svc_ext               = SVC_EXT_W'(in_service_ticks);
  assign new_entry.arrive_tick = tick_r;
  assign new_entry.service     = svc_ext[SERVICE_BITS-1:0];

  assign full = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign enq  = in_client_arrives && !full;

  // The tail slot follows the head by the current occupancy, modulo depth.
  assign tail_sum  = (OCC_W+1)'(head_r) + (OCC_W+1)'(occ_r);
  assign tail_wrap = (tail_sum >= (OCC_W+1)'(QUEUE_DEPTH)) ?
                     (tail_sum - (OCC_W+1)'(QUEUE_DEPTH)) : tail_sum;
  assign tail      = tail_wrap[PTR_W-1:0];

  assign head_inc = (PTR_W+1)'(head_r) + (PTR_W+1)'(1);

  // With an empty queue the only candidate for service is the client
  // arriving in this very tick, so it is taken straight from the input.
  assign head_entry = (occ_r == '0) ? new_entry : mem_head;

  assign occ_enq    = enq ? (occ_r + OCC_W'(1)) : occ_r;
  assign start      = (svc_rem_r == '0) && (occ_enq != '0);
  assign wait_ticks = tick_r - head_entry.arrive_tick;

  always_comb begin
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    svc_rem_nxt  = svc_rem_r;
    tick_nxt     = tick_r;
    arrived_nxt  = arrived_r;
    served_nxt   = served_r;
    turned_nxt   = turned_r;
    len_sum_nxt  = len_sum_r;
    wait_sum_nxt = wait_sum_r;
    len_add      = '0;
    wait_add     = '0;
    if (accept) begin
      tick_nxt = tick_r + TICK_W'(1);
      if (in_client_arrives) begin
        if (full) begin
          if (turned_r != '1) begin
            turned_nxt = turned_r + CNT_W'(1);
          end
        end else if (arrived_r != '1) begin
          arrived_nxt = arrived_r + CNT_W'(1);
        end
      end
      occ_nxt = occ_enq;
      if (start) begin
        occ_nxt  = occ_enq - OCC_W'(1);
        head_nxt = (head_inc == (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : head_inc[PTR_W-1:0];
        // Loading the service time and the first countdown fall in one tick.
        svc_rem_nxt = (head_entry.service == '0) ? '0 :
                      (head_entry.service - SERVICE_BITS'(1));
        if (served_r != '1) begin
          served_nxt = served_r + CNT_W'(1);
        end
        wait_add     = (SUM_W+1)'(wait_sum_r) + (SUM_W+1)'(wait_ticks);
        wait_sum_nxt = wait_add[SUM_W] ? '1 : wait_add[SUM_W-1:0];
      end else if (svc_rem_r != '0) begin
        svc_rem_nxt = svc_rem_r - SERVICE_BITS'(1);
      end
      len_add     = (SUM_W+1)'(len_sum_r) + (SUM_W+1)'(occ_nxt);
      len_sum_nxt = len_add[SUM_W] ? '1 : len_add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      occ_r      <= '0;
      svc_rem_r  <= '0;
      tick_r     <= '0;
      arrived_r  <= '0;
      served_r   <= '0;
      turned_r   <= '0;
      len_sum_r  <= '0;
      wait_sum_r <= '0;
    end else begin
      head_r     <= head_nxt;
      occ_r      <= occ_nxt;
      svc_rem_r  <= svc_rem_nxt;
      tick_r     <= tick_nxt;
      arrived_r  <= arrived_nxt;
      served_r   <= served_nxt;
      turned_r   <= turned_nxt;
      len_sum_r  <= len_sum_nxt;
      wait_sum_r <= wait_sum_nxt;
    end
  end

  // The RAM is always read at the next head, so that the head client is
  // ready in the following cycle whether or not a transaction is taken meanwhile.
  sqtm_queue_mem u_queue_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && enq),
    .wr_addr (tail),
    .wr_data (new_entry),
    .rd_addr (head_nxt),
    .rd_data (mem_head)
  );

  assign occ_ext                  = OCC_EXT_W'(occ_nxt);
  assign result.queue_length      = occ_ext[QLEN_W-1:0];
  assign result.arrived_total     = arrived_nxt;
  assign result.served_total      = served_nxt;
  assign result.turned_away_total = turned_nxt;
  assign result.length_sum        = len_sum_nxt;
  assign result.wait_sum          = wait_sum_nxt;
  assign result.started_service   = start;

  sqtm_result_t out_data;

  sqtm_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (skid_ready),
    .in_data   (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_queue_length      = out_data.queue_length;
  assign out_arrived_total     = out_data.arrived_total;
  assign out_served_total      = out_data.served_total;
  assign out_turned_away_total = out_data.turned_away_total;
  assign out_length_sum        = out_data.length_sum;
  assign out_wait_sum          = out_data.wait_sum;
  assign out_started_service   = out_data.started_service;

endmodule

`default_nettype wire
